// ===== rtl/hsa_pkg.sv =====
// shared types, constants and reciprocal table for the hue/saturation adjust block
package hsa_pkg;

    localparam int RECIP_SHIFT = 26;

    localparam logic [16:0] HUE_FULL   = 17'd92160;
    localparam logic [13:0] HUE_SECTOR = 14'd15360;
    localparam logic [18:0] HUE_BIAS   = 19'd184320;

    // truncating constant divides as multiply by reciprocal plus one correction
    localparam logic [19:0] RECIP_100   = 20'(((64'd1 << 26) - 64'd1) / 64'd100);
    localparam logic [17:0] RECIP_65535 = 18'(((64'd1 << 33) - 64'd1) / 64'd65535);
    localparam logic [17:0] RECIP_15    = 18'(((64'd1 << 21) - 64'd1) / 64'd15);
    localparam logic [8:0]  RECIP_257   = 9'(((64'd1 << 17) - 64'd1) / 64'd257);

    localparam logic [6:0]  PCT_DIV = 7'd100;
    localparam logic [8:0]  CH_DIV  = 9'd257;
    localparam logic [8:0]  SAT_RESET = 9'd100;

    // register indexes of the configuration port
    localparam logic CFG_HUE_SHIFT = 1'b0;
    localparam logic CFG_SAT_PCT   = 1'b1;

    typedef logic [RECIP_SHIFT-1:0] recip_tab_t [256];

    // floor((2^26 - 1) / x) by long division, zero for x == 0
    function automatic recip_tab_t build_recip();
        recip_tab_t tab;
        logic [RECIP_SHIFT-1:0] q;
        logic [8:0] rem;
        for (int x = 0; x < 256; x++)
        begin
            q = '0;
            rem = '0;
            for (int i = RECIP_SHIFT - 1; i >= 0; i--)
            begin
                rem = {rem[7:0], 1'b1};
                if (x != 0 && rem >= 9'(x))
                begin
                    rem = rem - 9'(x);
                    q[i] = 1'b1;
                end
            end
            tab[x] = q;
        end
        return tab;
    endfunction

    localparam recip_tab_t RECIP = build_recip();

    typedef struct packed {
        logic [16:0] h;      // may still be one sector past a full turn on red max
        logic [15:0] s;
        logic [7:0]  mx;
        logic [7:0]  a;
    } hsv_t;

    typedef struct packed {
        logic [2:0]  sector;
        logic [13:0] w;
        logic [15:0] sn;
        logic [15:0] v16;
        logic [7:0]  a;
    } adj_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } rgba_t;

endpackage

// ===== rtl/hsa_in_if.sv =====
// input pixel channel
interface hsa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

// ===== rtl/hsa_out_if.sv =====
// output pixel channel
interface hsa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

// ===== rtl/hsa_rgb2hsv.sv =====
// rgb to hsv front end: max/min, reciprocal divides for hue and saturation
module hsa_rgb2hsv
    import hsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  rgba_t      in_pix,
    output logic       out_valid,
    output hsv_t       out_hsv
);

    typedef struct packed {
        logic [24:0] nh;
        logic [23:0] ns;
        logic [25:0] rd;
        logic [25:0] rm;
        logic [7:0]  d;
        logic [7:0]  mx;
        logic        gray;
        logic [7:0]  a;
    } s1_t;

    typedef struct packed {
        logic [16:0] qh;
        logic [15:0] qs;
        logic [24:0] nh;
        logic [23:0] ns;
        logic [7:0]  d;
        logic [7:0]  mx;
        logic        gray;
        logic [7:0]  a;
    } s2_t;

    logic  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    s1_t   s1_reg, s1_next;
    s2_t   s2_reg, s2_next;
    hsv_t  s3_reg, s3_next;

    logic [7:0]  mx, mn, d;
    logic [10:0] num;
    logic [50:0] ph;
    logic [49:0] ps;
    logic [24:0] rem_h;
    logic [23:0] rem_s;

    always_comb
    begin
        mx = in_pix.r;
        mn = in_pix.r;
        if (in_pix.g > mx) mx = in_pix.g;
        if (in_pix.b > mx) mx = in_pix.b;
        if (in_pix.g < mn) mn = in_pix.g;
        if (in_pix.b < mn) mn = in_pix.b;
        d = mx - mn;
        // ties go to red, then green
        priority if (mx == in_pix.r)
            num = 11'(in_pix.g) + 11'(d) * 11'd6 - 11'(in_pix.b);
        else if (mx == in_pix.g)
            num = 11'(in_pix.b) + 11'(d) * 11'd2 - 11'(in_pix.r);
        else
            num = 11'(in_pix.r) + 11'(d) * 11'd4 - 11'(in_pix.g);
        s1_next.nh   = (25'(num) << 14) - (25'(num) << 10);
        s1_next.ns   = (24'(d) << 16) - 24'(d);
        s1_next.rd   = RECIP[d];
        s1_next.rm   = RECIP[mx];
        s1_next.d    = d;
        s1_next.mx   = mx;
        s1_next.gray = (d == 8'd0);
        s1_next.a    = in_pix.a;
    end

    always_comb
    begin
        ph = 51'(s1_reg.nh) * 51'(s1_reg.rd);
        ps = 50'(s1_reg.ns) * 50'(s1_reg.rm);
        s2_next.qh   = ph[42:26];
        s2_next.qs   = ps[41:26];
        s2_next.nh   = s1_reg.nh;
        s2_next.ns   = s1_reg.ns;
        s2_next.d    = s1_reg.d;
        s2_next.mx   = s1_reg.mx;
        s2_next.gray = s1_reg.gray;
        s2_next.a    = s1_reg.a;
    end

    always_comb
    begin
        rem_h = s2_reg.nh - 25'(s2_reg.qh * 25'(s2_reg.d));
        rem_s = s2_reg.ns - 24'(s2_reg.qs * 24'(s2_reg.mx));
        s3_next.h  = s2_reg.gray ? '0 : s2_reg.qh + 17'(rem_h >= 25'(s2_reg.d));
        s3_next.s  = s2_reg.gray ? '0 : s2_reg.qs + 16'(rem_s >= 24'(s2_reg.mx));
        s3_next.mx = s2_reg.mx;
        s3_next.a  = s2_reg.a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_hsv   = s3_reg;

endmodule

// ===== rtl/hsa_adjust.sv =====
// hue shift with wrap, saturation scale with clamp, sector split
module hsa_adjust
    import hsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [9:0] hue_shift,
    input  logic [8:0] saturation_percent,
    input  logic       in_valid,
    input  hsv_t       in_hsv,
    output logic       out_valid,
    output adj_t       out_adj
);

    typedef struct packed {
        logic [18:0] ht;
        logic [24:0] p;
        logic [15:0] v16;
        logic [7:0]  a;
    } a1_t;

    typedef struct packed {
        logic [16:0] h;
        logic [18:0] q;
        logic [24:0] p;
        logic [15:0] v16;
        logic [7:0]  a;
    } a2_t;

    logic  a1_valid_reg, a2_valid_reg, a3_valid_reg;
    a1_t   a1_reg, a1_next;
    a2_t   a2_reg, a2_next;
    adj_t  a3_reg, a3_next;

    logic [16:0] hw;
    logic [19:0] hsum;
    logic [44:0] pq;
    logic [18:0] hm;
    logic [24:0] rem_p;
    logic [18:0] sn;
    logic [16:0] f;

    always_comb
    begin
        hw = (in_hsv.h >= HUE_FULL) ? in_hsv.h - HUE_FULL : in_hsv.h;
        hsum = 20'(hw) + {{2{hue_shift[9]}}, hue_shift, 8'd0} + 20'(HUE_BIAS);
        a1_next.ht  = hsum[18:0];
        a1_next.p   = 25'(in_hsv.s) * 25'(saturation_percent);
        a1_next.v16 = 16'(in_hsv.mx) * 16'd257;
        a1_next.a   = in_hsv.a;
    end

    always_comb
    begin
        // sum stays below five full turns
        priority if (a1_reg.ht >= 19'(HUE_FULL) * 19'd4)
            hm = a1_reg.ht - 19'(HUE_FULL) * 19'd4;
        else if (a1_reg.ht >= 19'(HUE_FULL) * 19'd3)
            hm = a1_reg.ht - 19'(HUE_FULL) * 19'd3;
        else if (a1_reg.ht >= 19'(HUE_FULL) * 19'd2)
            hm = a1_reg.ht - 19'(HUE_FULL) * 19'd2;
        else if (a1_reg.ht >= 19'(HUE_FULL))
            hm = a1_reg.ht - 19'(HUE_FULL);
        else
            hm = a1_reg.ht;
        pq = 45'(a1_reg.p) * 45'(RECIP_100);
        a2_next.h   = hm[16:0];
        a2_next.q   = pq[44:26];
        a2_next.p   = a1_reg.p;
        a2_next.v16 = a1_reg.v16;
        a2_next.a   = a1_reg.a;
    end

    always_comb
    begin
        rem_p = a2_reg.p - 25'(a2_reg.q * 25'(PCT_DIV));
        sn = a2_reg.q + 19'(rem_p >= 25'(PCT_DIV));
        priority if (a2_reg.h >= 17'(HUE_SECTOR) * 17'd5)
        begin
            a3_next.sector = 3'd5;
            f = a2_reg.h - 17'(HUE_SECTOR) * 17'd5;
        end
        else if (a2_reg.h >= 17'(HUE_SECTOR) * 17'd4)
        begin
            a3_next.sector = 3'd4;
            f = a2_reg.h - 17'(HUE_SECTOR) * 17'd4;
        end
        else if (a2_reg.h >= 17'(HUE_SECTOR) * 17'd3)
        begin
            a3_next.sector = 3'd3;
            f = a2_reg.h - 17'(HUE_SECTOR) * 17'd3;
        end
        else if (a2_reg.h >= 17'(HUE_SECTOR) * 17'd2)
        begin
            a3_next.sector = 3'd2;
            f = a2_reg.h - 17'(HUE_SECTOR) * 17'd2;
        end
        else if (a2_reg.h >= 17'(HUE_SECTOR))
        begin
            a3_next.sector = 3'd1;
            f = a2_reg.h - 17'(HUE_SECTOR);
        end
        else
        begin
            a3_next.sector = 3'd0;
            f = a2_reg.h;
        end
        a3_next.w   = a3_next.sector[0] ? HUE_SECTOR - f[13:0] : f[13:0];
        a3_next.sn  = (sn > 19'd65535) ? 16'hFFFF : sn[15:0];
        a3_next.v16 = a2_reg.v16;
        a3_next.a   = a2_reg.a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_valid_reg <= 1'b0;
            a2_valid_reg <= 1'b0;
            a3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a1_valid_reg <= in_valid;
            a2_valid_reg <= a1_valid_reg;
            a3_valid_reg <= a2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= a1_next;
            a2_reg <= a2_next;
            a3_reg <= a3_next;
        end
    end

    assign out_valid = a3_valid_reg;
    assign out_adj   = a3_reg;

    a_hue_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        a2_valid_reg |-> a2_reg.h < HUE_FULL)
        else $error("wrapped hue out of range");

    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        a3_valid_reg |-> a3_reg.sector <= 3'd5)
        else $error("hue sector out of range");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        a3_valid_reg |-> a3_reg.w <= HUE_SECTOR)
        else $error("sector weight out of range");

endmodule

// ===== rtl/hsa_hsv2rgb.sv =====
// hsv to rgb back end: chroma, intermediate value, scale to 8 bits, sector mux
module hsa_hsv2rgb
    import hsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  adj_t       in_adj,
    output logic       out_valid,
    output rgba_t      out_pix
);

    typedef struct packed {
        logic [31:0] pc;
        logic [16:0] q;
        logic [2:0]  sector;
        logic [13:0] w;
        logic [15:0] v16;
        logic [7:0]  a;
    } b_t;

    typedef struct packed {
        logic [15:0] c;
        logic [29:0] px;
        logic [16:0] q;
        logic [2:0]  sector;
        logic [13:0] w;
        logic [15:0] v16;
        logic [7:0]  a;
    } c_t;

    typedef struct packed {
        logic [15:0] hi;
        logic [15:0] mid;
        logic [15:0] lo;
        logic [7:0]  qhi;
        logic [7:0]  qmid;
        logic [7:0]  qlo;
        logic [2:0]  sector;
        logic [7:0]  a;
    } d_t;

    logic  b1_valid_reg, b2_valid_reg, b3_valid_reg, b4_valid_reg;
    logic  b5_valid_reg, b6_valid_reg, b7_valid_reg, b8_valid_reg;
    b_t    b1_reg, b1_next, b2_reg, b2_next;
    c_t    b3_reg, b3_next, b4_reg, b4_next, b5_reg, b5_next;
    d_t    b6_reg, b6_next, b7_reg, b7_next;
    rgba_t b8_reg, b8_next;

    logic [49:0] cq;
    logic [31:0] rem_c;
    logic [37:0] xq;
    logic [19:0] n15;
    logic [19:0] rem_x;
    logic [15:0] x;
    logic [24:0] pv_hi, pv_mid, pv_lo;
    logic [7:0]  ch_hi, ch_mid, ch_lo;

    function automatic logic [7:0] fix257(input logic [15:0] v, input logic [7:0] q);
        logic [15:0] rem;
        rem = v - 16'(q * 16'(CH_DIV));
        return q + 8'(rem >= 16'(CH_DIV));
    endfunction

    always_comb
    begin
        b1_next        = '0;
        b1_next.pc     = 32'(in_adj.v16) * 32'(in_adj.sn);
        b1_next.sector = in_adj.sector;
        b1_next.w      = in_adj.w;
        b1_next.v16    = in_adj.v16;
        b1_next.a      = in_adj.a;
    end

    always_comb
    begin
        cq = 50'(b1_reg.pc) * 50'(RECIP_65535);
        b2_next   = b1_reg;
        b2_next.q = cq[49:33];
    end

    always_comb
    begin
        rem_c = b2_reg.pc - 32'(b2_reg.q * 32'd65535);
        b3_next        = '0;
        b3_next.c      = 16'(b2_reg.q + 17'(rem_c >= 32'd65535));
        b3_next.sector = b2_reg.sector;
        b3_next.w      = b2_reg.w;
        b3_next.v16    = b2_reg.v16;
        b3_next.a      = b2_reg.a;
    end

    always_comb
    begin
        b4_next    = b3_reg;
        b4_next.px = 30'(b3_reg.c) * 30'(b3_reg.w);
    end

    always_comb
    begin
        // divide by the sector size: drop the power-of-two part, then divide by 15
        n15 = b4_reg.px[29:10];
        xq = 38'(n15) * 38'(RECIP_15);
        b5_next   = b4_reg;
        b5_next.q = xq[37:21];
    end

    always_comb
    begin
        rem_x = b5_reg.px[29:10] - 20'(b5_reg.q * 20'd15);
        x = 16'(b5_reg.q + 17'(rem_x >= 20'd15));
        b6_next        = '0;
        b6_next.hi     = b5_reg.v16;
        b6_next.lo     = b5_reg.v16 - b5_reg.c;
        b6_next.mid    = b5_reg.v16 - b5_reg.c + x;
        b6_next.sector = b5_reg.sector;
        b6_next.a      = b5_reg.a;
    end

    always_comb
    begin
        pv_hi  = 25'(b6_reg.hi)  * 25'(RECIP_257);
        pv_mid = 25'(b6_reg.mid) * 25'(RECIP_257);
        pv_lo  = 25'(b6_reg.lo)  * 25'(RECIP_257);
        b7_next      = b6_reg;
        b7_next.qhi  = pv_hi[24:17];
        b7_next.qmid = pv_mid[24:17];
        b7_next.qlo  = pv_lo[24:17];
    end

    always_comb
    begin
        ch_hi  = fix257(b7_reg.hi,  b7_reg.qhi);
        ch_mid = fix257(b7_reg.mid, b7_reg.qmid);
        ch_lo  = fix257(b7_reg.lo,  b7_reg.qlo);
        b8_next.a = b7_reg.a;
        unique case (b7_reg.sector)
            3'd0:
            begin
                b8_next.r = ch_hi;  b8_next.g = ch_mid; b8_next.b = ch_lo;
            end
            3'd1:
            begin
                b8_next.r = ch_mid; b8_next.g = ch_hi;  b8_next.b = ch_lo;
            end
            3'd2:
            begin
                b8_next.r = ch_lo;  b8_next.g = ch_hi;  b8_next.b = ch_mid;
            end
            3'd3:
            begin
                b8_next.r = ch_lo;  b8_next.g = ch_mid; b8_next.b = ch_hi;
            end
            3'd4:
            begin
                b8_next.r = ch_mid; b8_next.g = ch_lo;  b8_next.b = ch_hi;
            end
            default:
            begin
                b8_next.r = ch_hi;  b8_next.g = ch_lo;  b8_next.b = ch_mid;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
            b5_valid_reg <= 1'b0;
            b6_valid_reg <= 1'b0;
            b7_valid_reg <= 1'b0;
            b8_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= in_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
            b5_valid_reg <= b4_valid_reg;
            b6_valid_reg <= b5_valid_reg;
            b7_valid_reg <= b6_valid_reg;
            b8_valid_reg <= b7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg <= b1_next;
            b2_reg <= b2_next;
            b3_reg <= b3_next;
            b4_reg <= b4_next;
            b5_reg <= b5_next;
            b6_reg <= b6_next;
            b7_reg <= b7_next;
            b8_reg <= b8_next;
        end
    end

    assign out_valid = b8_valid_reg;
    assign out_pix   = b8_reg;

endmodule

// ===== rtl/hue_saturation_adjust.sv =====
// Hue/saturation adjust of an RGBA pixel stream. A pixel is taken every clock while the
// pipeline is not held, and each pixel passes through the fourteen-stage pipeline that
// holds the rgb-to-hsv divides, the hue wrap and saturation scale, and the hsv-to-rgb
// multiplies, each divide done as a reciprocal multiply followed by a one-step correction.
// When the output beat is not taken the whole pipeline holds, so input ready is low only
// while a finished pixel waits. Configuration writes are meant for when the pipe is empty.
module hue_saturation_adjust
    import hsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hsa_in_if.sink      pix_in,
    hsa_out_if.source   pix_out,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data
);

    logic [9:0] hue_shift_reg;
    logic [8:0] sat_pct_reg;
    logic       en;
    rgba_t      in_pix;
    logic       hsv_valid, adj_valid, rgb_valid;
    hsv_t       hsv;
    adj_t       adj;
    rgba_t      rgb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_shift_reg <= '0;
            sat_pct_reg   <= SAT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HUE_SHIFT: hue_shift_reg <= cfg_data;
                CFG_SAT_PCT:   sat_pct_reg   <= cfg_data[8:0];
                default:       ;
            endcase
        end
    end

    // the pipe moves unless a finished beat is waiting at the output
    assign en = !(rgb_valid && !pix_out.ready);
    assign pix_in.ready = en;

    assign in_pix.r = pix_in.red_in;
    assign in_pix.g = pix_in.green_in;
    assign in_pix.b = pix_in.blue_in;
    assign in_pix.a = pix_in.alpha_in;

    hsa_rgb2hsv u_rgb2hsv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pix_in.valid),
        .in_pix    (in_pix),
        .out_valid (hsv_valid),
        .out_hsv   (hsv)
    );

    hsa_adjust u_adjust (
        .clk                (clk),
        .rst_n              (rst_n),
        .en                 (en),
        .hue_shift          (hue_shift_reg),
        .saturation_percent (sat_pct_reg),
        .in_valid           (hsv_valid),
        .in_hsv             (hsv),
        .out_valid          (adj_valid),
        .out_adj            (adj)
    );

    hsa_hsv2rgb u_hsv2rgb (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (adj_valid),
        .in_adj    (adj),
        .out_valid (rgb_valid),
        .out_pix   (rgb)
    );

    assign pix_out.valid     = rgb_valid;
    assign pix_out.red_out   = rgb.r;
    assign pix_out.green_out = rgb.g;
    assign pix_out.blue_out  = rgb.b;
    assign pix_out.alpha_out = rgb.a;

endmodule
